@@ rtl/core/hrhp_pkg.sv @@
// Shared types, codes and header-name, header-value and status literals for the HTTP response header parser.
`timescale 1ns / 1ps

package hrhp_pkg;

   localparam int MAX_HEADER_BYTES_DEFAULT = 65536;

   localparam int LIT_WIDTH = 136;

   localparam logic [LIT_WIDTH-1:0] LIT_CLEN    = "Content-Length";
   localparam logic [LIT_WIDTH-1:0] LIT_TENC    = "Transfer-Encoding";
   localparam logic [LIT_WIDTH-1:0] LIT_CENC    = "Content-Encoding";
   localparam logic [LIT_WIDTH-1:0] LIT_CHUNKED = "chunked";
   localparam logic [LIT_WIDTH-1:0] LIT_GZIP    = "gzip";
   localparam logic [LIT_WIDTH-1:0] LIT_200     = "200";

   localparam logic [4:0] LEN_CLEN    = 5'd14;
   localparam logic [4:0] LEN_TENC    = 5'd17;
   localparam logic [4:0] LEN_CENC    = 5'd16;
   localparam logic [4:0] LEN_CHUNKED = 5'd7;
   localparam logic [4:0] LEN_GZIP    = 5'd4;
   localparam logic [4:0] LEN_200     = 5'd3;

   typedef enum logic [2:0] {
      KIND_VERSION = 3'd0,
      KIND_STATUS  = 3'd1,
      KIND_REASON  = 3'd2,
      KIND_KEY     = 3'd3,
      KIND_VALUE   = 3'd4,
      KIND_DONE    = 3'd5,
      KIND_ERROR   = 3'd6
   } token_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_STRAY_CR  = 3'd1,
      ERR_STRAY_LF  = 3'd2,
      ERR_STATUS    = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } error_code_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      logic           status_ok;
      logic [31:0]    content_length;
      logic           chunked;
      logic           gzip;
      error_code_type error_code;
   } result_type;

   // True when the character at index i of a literal of length n equals c.
   function automatic logic lit_match(input logic [LIT_WIDTH-1:0] s, input logic [4:0] n,
                                      input logic [15:0] i, input logic [7:0] c);
      logic [7:0] base;
      base = {n - 5'd1 - i[4:0], 3'b000};
      return (i < {11'd0, n}) && (s[base +: 8] == c);
   endfunction

endpackage

@@ rtl/core/http_response_header_parser_top.sv @@
// Top level of the HTTP response header parser with its output register.
// Latency: a token appears on the result channel in the cycle after the byte beat that ends it.
// Throughput: one byte beat per cycle while req_stall is low, set by the parser's per-beat state update.
// A stalled result stalls the input only while the output register is full.
// Reset clears the parser to the start of a status line and empties the output register.
`timescale 1ns / 1ps

module http_response_header_parser_top #(
   parameter int MAX_HEADER_BYTES = hrhp_pkg::MAX_HEADER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_status_ok,
   output logic [31:0] rsp_content_length,
   output logic        rsp_chunked,
   output logic        rsp_gzip,
   output logic [2:0]  rsp_error_code
);

   logic                 rsp_valid_ff, rsp_valid_in;
   hrhp_pkg::result_type rsp_data_ff;
   hrhp_pkg::result_type result;
   logic                 step;
   logic                 emit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step = req_valid && !req_stall;

   hrhp_parser #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .step(step),
      .op(req_op),
      .data_byte(req_data_byte),
      .emit(emit),
      .result(result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_token_kind = rsp_data_ff.kind;
   assign rsp_token_start = rsp_data_ff.start;
   assign rsp_token_length = rsp_data_ff.length;
   assign rsp_status_ok = rsp_data_ff.status_ok;
   assign rsp_content_length = rsp_data_ff.content_length;
   assign rsp_chunked = rsp_data_ff.chunked;
   assign rsp_gzip = rsp_data_ff.gzip;
   assign rsp_error_code = rsp_data_ff.error_code;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled while the output register is empty");

   a_error_code_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_token_kind == hrhp_pkg::KIND_ERROR) ==
                        (rsp_error_code != hrhp_pkg::ERR_NONE)))
      else $error("error code disagrees with token kind");

   a_summary_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_token_kind != hrhp_pkg::KIND_DONE) |->
         !rsp_status_ok && !rsp_chunked && !rsp_gzip && (rsp_content_length == 32'd0))
      else $error("header summary fields set outside header complete");

   a_no_emit_on_restart: assert property (@(posedge clock) disable iff (reset)
      step && req_op |=> !rsp_valid_ff || $past(rsp_stall))
      else $error("restart beat produced a result");

endmodule

@@ rtl/core/hrhp_parser.sv @@
// Per-byte state machine over the status line and header lines.
`timescale 1ns / 1ps

module hrhp_parser #(
   parameter int MAX_HEADER_BYTES = hrhp_pkg::MAX_HEADER_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 op,
   input  logic [7:0]           data_byte,
   output logic                 emit,
   output hrhp_pkg::result_type result
);

   localparam int LIMIT = (MAX_HEADER_BYTES < 65536) ? MAX_HEADER_BYTES : 65536;
   localparam int PW = $clog2(LIMIT + 1);

   typedef enum logic [3:0] {
      PH_VERSION   = 4'd0,
      PH_STATUS    = 4'd1,
      PH_REASON    = 4'd2,
      PH_REASON_CR = 4'd3,
      PH_KEY       = 4'd4,
      PH_VALUE     = 4'd5,
      PH_LINE_CR   = 4'd6,
      PH_END_CR    = 4'd7,
      PH_DONE      = 4'd8,
      PH_FAILED    = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      KEY_NONE = 2'd0,
      KEY_CLEN = 2'd1,
      KEY_TENC = 2'd2,
      KEY_CENC = 2'd3
   } key_type;

   phase_type   phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] cts_ff, cts_in;
   logic [2:0]  key_cand_ff, key_cand_in;
   key_type     key_ff, key_in;
   logic [1:0]  val_cand_ff, val_cand_in;
   logic        lead_ff, lead_in;
   logic        status_ff, status_in;
   logic [31:0] acc_ff, acc_in;
   logic        chunked_ff, chunked_in;
   logic        gzip_ff, gzip_in;
   logic        finished_ff, finished_in;

   logic [PW-1:0] diff;
   logic [15:0]   rel;
   logic [35:0]   scaled;
   logic          is_digit;
   logic          emit_int;

   assign diff = pos_ff - cts_ff;
   assign rel = 16'(diff);
   assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
   assign scaled = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {32'd0, data_byte[3:0]};
   assign emit = step && emit_int;

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      cts_in = cts_ff;
      key_cand_in = key_cand_ff;
      key_in = key_ff;
      val_cand_in = val_cand_ff;
      lead_in = lead_ff;
      status_in = status_ff;
      acc_in = acc_ff;
      chunked_in = chunked_ff;
      gzip_in = gzip_ff;
      finished_in = finished_ff;
      emit_int = 1'b0;
      result = '0;
      result.kind = hrhp_pkg::KIND_VERSION;
      result.error_code = hrhp_pkg::ERR_NONE;
      if (op) begin
         phase_in = PH_VERSION;
         pos_in = '0;
         cts_in = '0;
         key_cand_in = 3'b111;
         key_in = KEY_NONE;
         val_cand_in = 2'b11;
         lead_in = 1'b0;
         status_in = 1'b1;
         acc_in = '0;
         chunked_in = 1'b0;
         gzip_in = 1'b0;
         finished_in = 1'b0;
      end else if (!finished_ff) begin
         if (pos_ff >= PW'(LIMIT)) begin
            phase_in = PH_FAILED;
            finished_in = 1'b1;
            emit_int = 1'b1;
            result.kind = hrhp_pkg::KIND_ERROR;
            result.error_code = hrhp_pkg::ERR_OVERFLOW;
         end else begin
            pos_in = pos_ff + 1'b1;
            result.start = 16'(cts_ff);
            result.length = rel;
            if (data_byte == 8'h0D) begin
               case (phase_ff)
                  PH_REASON: begin
                     phase_in = PH_REASON_CR;
                     cts_in = pos_ff + 1'b1;
                     emit_int = 1'b1;
                     result.kind = hrhp_pkg::KIND_REASON;
                  end
                  PH_KEY: begin
                     phase_in = PH_END_CR;
                  end
                  PH_VALUE: begin
                     phase_in = PH_LINE_CR;
                     if (key_ff == KEY_TENC && val_cand_ff[0] && rel == 16'd7) begin
                        chunked_in = 1'b1;
                     end
                     if (key_ff == KEY_CENC && val_cand_ff[1] && rel == 16'd4) begin
                        gzip_in = 1'b1;
                     end
                     emit_int = 1'b1;
                     result.kind = hrhp_pkg::KIND_VALUE;
                  end
                  default: begin
                     phase_in = PH_FAILED;
                     finished_in = 1'b1;
                     emit_int = 1'b1;
                     result = '0;
                     result.kind = hrhp_pkg::KIND_ERROR;
                     result.start = 16'(pos_ff);
                     result.error_code = hrhp_pkg::ERR_STRAY_CR;
                  end
               endcase
            end else if (data_byte == 8'h0A) begin
               case (phase_ff)
                  PH_REASON_CR, PH_LINE_CR: begin
                     phase_in = PH_KEY;
                     cts_in = pos_ff + 1'b1;
                     key_cand_in = 3'b111;
                  end
                  PH_END_CR: begin
                     finished_in = 1'b1;
                     emit_int = 1'b1;
                     result = '0;
                     result.start = 16'(pos_ff);
                     if (!status_ff) begin
                        phase_in = PH_FAILED;
                        result.kind = hrhp_pkg::KIND_ERROR;
                        result.error_code = hrhp_pkg::ERR_STATUS;
                     end else begin
                        phase_in = PH_DONE;
                        result.kind = hrhp_pkg::KIND_DONE;
                        result.error_code = hrhp_pkg::ERR_NONE;
                        result.status_ok = 1'b1;
                        result.content_length = acc_ff;
                        result.chunked = chunked_ff;
                        result.gzip = gzip_ff;
                     end
                  end
                  default: begin
                     phase_in = PH_FAILED;
                     finished_in = 1'b1;
                     emit_int = 1'b1;
                     result = '0;
                     result.kind = hrhp_pkg::KIND_ERROR;
                     result.start = 16'(pos_ff);
                     result.error_code = hrhp_pkg::ERR_STRAY_LF;
                  end
               endcase
            end else begin
               case (phase_ff)
                  PH_VERSION: begin
                     if (data_byte == 8'h20) begin
                        phase_in = PH_STATUS;
                        cts_in = pos_ff + 1'b1;
                        status_in = 1'b1;
                        emit_int = 1'b1;
                        result.kind = hrhp_pkg::KIND_VERSION;
                     end
                  end
                  PH_STATUS: begin
                     if (data_byte == 8'h20) begin
                        if (rel != 16'd3) begin
                           status_in = 1'b0;
                        end
                        phase_in = PH_REASON;
                        cts_in = pos_ff + 1'b1;
                        emit_int = 1'b1;
                        result.kind = hrhp_pkg::KIND_STATUS;
                     end else if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_200, hrhp_pkg::LEN_200,
                                                       rel, data_byte)) begin
                        status_in = 1'b0;
                     end
                  end
                  PH_KEY: begin
                     if (data_byte == 8'h3A) begin
                        if (key_cand_ff[0] && rel == 16'd14) begin
                           key_in = KEY_CLEN;
                           acc_in = '0;
                        end else if (key_cand_ff[1] && rel == 16'd17) begin
                           key_in = KEY_TENC;
                        end else if (key_cand_ff[2] && rel == 16'd16) begin
                           key_in = KEY_CENC;
                        end else begin
                           key_in = KEY_NONE;
                        end
                        phase_in = PH_VALUE;
                        cts_in = pos_ff + 1'b1;
                        val_cand_in = 2'b11;
                        lead_in = 1'b1;
                        emit_int = 1'b1;
                        result.kind = hrhp_pkg::KIND_KEY;
                     end else begin
                        if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_CLEN, hrhp_pkg::LEN_CLEN,
                                                 rel, data_byte)) begin
                           key_cand_in[0] = 1'b0;
                        end
                        if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_TENC, hrhp_pkg::LEN_TENC,
                                                 rel, data_byte)) begin
                           key_cand_in[1] = 1'b0;
                        end
                        if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_CENC, hrhp_pkg::LEN_CENC,
                                                 rel, data_byte)) begin
                           key_cand_in[2] = 1'b0;
                        end
                     end
                  end
                  PH_VALUE: begin
                     if (data_byte == 8'h20 && lead_ff) begin
                        cts_in = pos_ff + 1'b1;
                     end else begin
                        lead_in = 1'b0;
                        if (key_ff == KEY_CLEN) begin
                           if (val_cand_ff[0] && is_digit) begin
                              acc_in = (scaled[35:32] != 4'd0) ? 32'hFFFF_FFFF : scaled[31:0];
                           end else begin
                              val_cand_in[0] = 1'b0;
                           end
                        end else begin
                           if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_CHUNKED,
                                                    hrhp_pkg::LEN_CHUNKED, rel, data_byte)) begin
                              val_cand_in[0] = 1'b0;
                           end
                           if (!hrhp_pkg::lit_match(hrhp_pkg::LIT_GZIP, hrhp_pkg::LEN_GZIP,
                                                    rel, data_byte)) begin
                              val_cand_in[1] = 1'b0;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION;
         pos_ff <= '0;
         cts_ff <= '0;
         key_cand_ff <= 3'b111;
         key_ff <= KEY_NONE;
         val_cand_ff <= 2'b11;
         lead_ff <= 1'b0;
         status_ff <= 1'b1;
         acc_ff <= '0;
         chunked_ff <= 1'b0;
         gzip_ff <= 1'b0;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         cts_ff <= cts_in;
         key_cand_ff <= key_cand_in;
         key_ff <= key_in;
         val_cand_ff <= val_cand_in;
         lead_ff <= lead_in;
         status_ff <= status_in;
         acc_ff <= acc_in;
         chunked_ff <= chunked_in;
         gzip_ff <= gzip_in;
         finished_ff <= finished_in;
      end
   end

endmodule
